[sv/lrk4_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrk4_pkg
// Shared widths, constants and the saturation helper of the Lorenz RK4 unit.
// ----------------------------------------------------------------------------
package lrk4_pkg;

   localparam int WIDE_W   = 72;
   localparam int Q_W      = 32;
   localparam int MUL_A_W  = 36;
   localparam int MUL_B_W  = 32;
   localparam int PROD_W   = 68;
   localparam int DIV_IN_W = 36;
   localparam int DIV_W    = 40;
   localparam int DIV_STEPS  = 8;
   localparam int DIV_CYCLES = DIV_W / DIV_STEPS;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

   localparam logic signed [WIDE_W-1:0] SAT_MAX = 72'sd2147483647;
   localparam logic signed [WIDE_W-1:0] SAT_MIN = -72'sd2147483648;

   function automatic logic signed [Q_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      if (v > SAT_MAX) begin
         return 32'sh7fffffff;
      end else if (v < SAT_MIN) begin
         return 32'sh80000000;
      end
      return signed'(v[Q_W-1:0]);
   endfunction

endpackage

[sv/lrk4_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrk4_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module lrk4_mul (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic signed [lrk4_pkg::MUL_A_W-1:0]    a,
   input  logic signed [lrk4_pkg::MUL_B_W-1:0]    b,
   output logic signed [lrk4_pkg::PROD_W-1:0]     prod
);

   logic signed [lrk4_pkg::PROD_W-1:0] prod_ff;
   logic signed [lrk4_pkg::PROD_W-1:0] prod_in;

   assign prod_in = lrk4_pkg::PROD_W'(a) * lrk4_pkg::PROD_W'(b);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

[sv/lrk4_div6.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrk4_div6
// Iterative floor division of a signed value by six, several bits a cycle.
// ----------------------------------------------------------------------------
module lrk4_div6 (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic signed [lrk4_pkg::DIV_IN_W-1:0]    dividend,
   output logic                                    done,
   output logic signed [lrk4_pkg::DIV_IN_W-1:0]    quotient
);

   localparam logic signed [40:0] BIAS = 41'sd51539607552;   // 6 * 2^33
   localparam logic signed [lrk4_pkg::DIV_IN_W-1:0] OFFSET = 36'sd8589934592;

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [lrk4_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [lrk4_pkg::DIV_W-1:0]        work_ff, work_in;
   logic [2:0]                        rem_ff, rem_in;
   logic signed [40:0]                biased;

   assign biased = 41'(dividend) + BIAS;

   always_comb begin
      logic [lrk4_pkg::DIV_W-1:0] w;
      logic [2:0]                 r;
      logic [3:0]                 r4;
      w       = work_ff;
      r       = rem_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      for (int i = 0; i < lrk4_pkg::DIV_STEPS; i++) begin
         r4 = {r, w[lrk4_pkg::DIV_W-1]};
         w  = {w[lrk4_pkg::DIV_W-2:0], 1'b0};
         if (r4 >= 4'd6) begin
            r    = 3'(r4 - 4'd6);
            w[0] = 1'b1;
         end else begin
            r = r4[2:0];
         end
      end
      work_in = work_ff;
      rem_in  = rem_ff;
      if (start) begin
         work_in = lrk4_pkg::DIV_W'(biased);
         rem_in  = 3'd0;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         work_in = w;
         rem_in  = r;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == lrk4_pkg::DIV_CNT_W'(lrk4_pkg::DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = signed'(work_ff[lrk4_pkg::DIV_IN_W-1:0]) - OFFSET;

endmodule

[sv/lorenz_rk4_integrator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lorenz_rk4_integrator_unit
// Lorenz system state in signed fixed point, advanced by classical RK4 steps.
// ----------------------------------------------------------------------------
// A request beat (req_valid high, req_stall low) carries req_kind: 0 advances
// the state by one RK4 step of size dt, 1 loads the state from req_load_*.
// Each request yields one response beat with the new state and the plot
// coordinates x*0.075, (z-25)*0.075 and y*0.075, all saturated to 32 bits.
// dt is written through csr_wr_en / csr_wr_data; the user must write it only
// while the unit is idle, which the unit itself does not enforce. All products
// go through one shared multiplier, each in a multiply and a write-back state;
// each of the three final divisions by six waits on the iterative divider.
// req_stall is high from accept until the result moves to the output
// register; a previous response may still wait there while the next request
// is taken. If the receiver stalls, the finished result waits in the unit.
// Reset restores x, y, z to 0.9, 1.7, 21.0 and dt to about 0.0042.
// ----------------------------------------------------------------------------
module lorenz_rk4_integrator_unit #(
   parameter int FRAC_BITS = 20
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic signed [31:0] req_load_x,
   input  logic signed [31:0] req_load_y,
   input  logic signed [31:0] req_load_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_state_x,
   output logic signed [31:0] rsp_state_y,
   output logic signed [31:0] rsp_state_z,
   output logic signed [31:0] rsp_plot_x,
   output logic signed [31:0] rsp_plot_y,
   output logic signed [31:0] rsp_plot_z,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);

   localparam int WW = lrk4_pkg::WIDE_W;
   localparam logic signed [WW-1:0] RHO_Q   = 72'sd28 <<< FRAC_BITS;
   localparam logic signed [WW-1:0] K25_Q   = 72'sd25 <<< FRAC_BITS;
   localparam logic signed [WW-1:0] BETA_Q  = ((72'sd16 <<< FRAC_BITS) + 72'sd3) / 72'sd6;
   localparam logic signed [WW-1:0] PLOT_Q  = ((72'sd6 <<< FRAC_BITS) + 72'sd40) / 72'sd80;
   localparam logic signed [WW-1:0] X0_Q    = ((72'sd18 <<< FRAC_BITS) + 72'sd10) / 72'sd20;
   localparam logic signed [WW-1:0] Y0_Q    = ((72'sd34 <<< FRAC_BITS) + 72'sd10) / 72'sd20;
   localparam logic signed [WW-1:0] Z0_Q    = 72'sd21 <<< FRAC_BITS;
   localparam logic signed [WW-1:0] DT0_Q   =
      ((72'sd84 <<< FRAC_BITS) + 72'sd10000) / 72'sd20000;
   localparam logic signed [WW-1:0] HALF_F  = 72'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [WW-1:0] HALF_F1 = 72'sd1 <<< FRAC_BITS;
   localparam logic signed [WW-1:0] THREE_F = 72'sd3 <<< FRAC_BITS;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_WB, ST_DIV, ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_DY, OP_DZA, OP_DZB, OP_PX, OP_PY, OP_PZ,
      OP_FX, OP_FY, OP_FZ, OP_PLX, OP_PLY, OP_PLZ
   } op_type;

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [1:0]         stage_ff, stage_in;
   logic [15:0]        dt_ff, dt_in;
   logic signed [31:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [31:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic signed [31:0] kx_ff, kx_in, ky_ff, ky_in, kz_ff, kz_in;
   logic signed [47:0] tmp_ff, tmp_in;
   logic signed [35:0] sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;
   logic signed [31:0] plx_ff, plx_in, ply_ff, ply_in, plz_ff, plz_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_sx_ff, rsp_sx_in, rsp_sy_ff, rsp_sy_in, rsp_sz_ff, rsp_sz_in;
   logic signed [31:0] rsp_px_ff, rsp_px_in, rsp_py_ff, rsp_py_in, rsp_pz_ff, rsp_pz_in;

   logic signed [lrk4_pkg::MUL_A_W-1:0]  mul_a;
   logic signed [lrk4_pkg::MUL_B_W-1:0]  mul_b;
   logic signed [lrk4_pkg::PROD_W-1:0]   prod;
   logic signed [WW-1:0]                 prod_w, rnd_f, rnd_f1, diff, ten;
   logic signed [lrk4_pkg::DIV_IN_W-1:0] div_arg, div_q;
   logic                                 div_start, div_done;
   logic signed [31:0]                   dt_s;
   logic                                 accept, w2;

   assign accept = req_valid && !req_stall;
   assign dt_s   = signed'({16'd0, dt_ff});
   assign prod_w = WW'(prod);
   assign rnd_f  = (prod_w + HALF_F) >>> FRAC_BITS;
   assign rnd_f1 = (prod_w + HALF_F1) >>> (FRAC_BITS + 1);
   assign div_arg = lrk4_pkg::DIV_IN_W'((prod_w + THREE_F) >>> FRAC_BITS);
   assign diff   = WW'(py_ff) - WW'(px_ff);
   assign ten    = (diff <<< 3) + (diff <<< 1);
   assign w2     = (stage_ff == 2'd1) || (stage_ff == 2'd2);

   always_comb begin
      mul_a = 36'(x_ff);
      mul_b = PLOT_Q[31:0];
      case (op_ff)
         OP_DY: begin
            mul_a = 36'(lrk4_pkg::sat32(RHO_Q - WW'(pz_ff)));
            mul_b = px_ff;
         end
         OP_DZA: begin
            mul_a = 36'(px_ff);
            mul_b = py_ff;
         end
         OP_DZB: begin
            mul_a = BETA_Q[35:0];
            mul_b = pz_ff;
         end
         OP_PX: begin
            mul_a = 36'(kx_ff);
            mul_b = dt_s;
         end
         OP_PY: begin
            mul_a = 36'(ky_ff);
            mul_b = dt_s;
         end
         OP_PZ: begin
            mul_a = 36'(kz_ff);
            mul_b = dt_s;
         end
         OP_FX: begin
            mul_a = sx_ff;
            mul_b = dt_s;
         end
         OP_FY: begin
            mul_a = sy_ff;
            mul_b = dt_s;
         end
         OP_FZ: begin
            mul_a = sz_ff;
            mul_b = dt_s;
         end
         OP_PLY: begin
            mul_a = 36'(lrk4_pkg::sat32(WW'(z_ff) - K25_Q));
         end
         OP_PLZ: begin
            mul_a = 36'(y_ff);
         end
         default: begin
            mul_a = 36'(x_ff);
         end
      endcase
   end

   lrk4_mul u_mul (
      .clock (clock),
      .en    (state_ff == ST_MUL),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   lrk4_div6 u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_arg),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      stage_in  = stage_ff;
      dt_in     = dt_ff;
      x_in = x_ff;   y_in = y_ff;   z_in = z_ff;
      px_in = px_ff; py_in = py_ff; pz_in = pz_ff;
      kx_in = kx_ff; ky_in = ky_ff; kz_in = kz_ff;
      tmp_in = tmp_ff;
      sx_in = sx_ff; sy_in = sy_ff; sz_in = sz_ff;
      plx_in = plx_ff; ply_in = ply_ff; plz_in = plz_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_sx_in = rsp_sx_ff; rsp_sy_in = rsp_sy_ff; rsp_sz_in = rsp_sz_ff;
      rsp_px_in = rsp_px_ff; rsp_py_in = rsp_py_ff; rsp_pz_in = rsp_pz_ff;
      div_start = 1'b0;

      if (csr_wr_en) begin
         dt_in = csr_wr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MUL;
               if (req_kind) begin
                  x_in  = req_load_x;
                  y_in  = req_load_y;
                  z_in  = req_load_z;
                  op_in = OP_PLX;
               end else begin
                  px_in = x_ff;
                  py_in = y_ff;
                  pz_in = z_ff;
                  sx_in = '0;
                  sy_in = '0;
                  sz_in = '0;
                  stage_in = 2'd0;
                  op_in = OP_DY;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_WB;
         end
         ST_WB: begin
            state_in = ST_MUL;
            unique case (op_ff)
               OP_DY: begin
                  ky_in = lrk4_pkg::sat32(rnd_f - WW'(py_ff));
                  op_in = OP_DZA;
               end
               OP_DZA: begin
                  tmp_in = 48'(rnd_f);
                  kx_in  = lrk4_pkg::sat32(ten);
                  op_in  = OP_DZB;
               end
               OP_DZB: begin
                  kz_in = lrk4_pkg::sat32(WW'(tmp_ff) - rnd_f);
                  sx_in = sx_ff + (w2 ? (36'(kx_ff) <<< 1) : 36'(kx_ff));
                  sy_in = sy_ff + (w2 ? (36'(ky_ff) <<< 1) : 36'(ky_ff));
                  sz_in = sz_ff + (w2 ? (36'(kz_in) <<< 1) : 36'(kz_in));
                  op_in = (stage_ff == 2'd3) ? OP_FX : OP_PX;
               end
               OP_PX: begin
                  px_in = lrk4_pkg::sat32(WW'(x_ff) + ((stage_ff == 2'd2) ? rnd_f : rnd_f1));
                  op_in = OP_PY;
               end
               OP_PY: begin
                  py_in = lrk4_pkg::sat32(WW'(y_ff) + ((stage_ff == 2'd2) ? rnd_f : rnd_f1));
                  op_in = OP_PZ;
               end
               OP_PZ: begin
                  pz_in = lrk4_pkg::sat32(WW'(z_ff) + ((stage_ff == 2'd2) ? rnd_f : rnd_f1));
                  stage_in = stage_ff + 2'd1;
                  op_in = OP_DY;
               end
               OP_FX, OP_FY, OP_FZ: begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
               OP_PLX: begin
                  plx_in = lrk4_pkg::sat32(rnd_f);
                  op_in  = OP_PLY;
               end
               OP_PLY: begin
                  ply_in = lrk4_pkg::sat32(rnd_f);
                  op_in  = OP_PLZ;
               end
               OP_PLZ: begin
                  plz_in   = lrk4_pkg::sat32(rnd_f);
                  state_in = ST_DONE;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_MUL;
               unique case (op_ff)
                  OP_FX: begin
                     x_in  = lrk4_pkg::sat32(WW'(x_ff) + WW'(div_q));
                     op_in = OP_FY;
                  end
                  OP_FY: begin
                     y_in  = lrk4_pkg::sat32(WW'(y_ff) + WW'(div_q));
                     op_in = OP_FZ;
                  end
                  default: begin
                     z_in  = lrk4_pkg::sat32(WW'(z_ff) + WW'(div_q));
                     op_in = OP_PLX;
                  end
               endcase
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_sx_in = x_ff;
               rsp_sy_in = y_ff;
               rsp_sz_in = z_ff;
               rsp_px_in = plx_ff;
               rsp_py_in = ply_ff;
               rsp_pz_in = plz_ff;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_DY;
         stage_ff     <= 2'd0;
         dt_ff        <= DT0_Q[15:0];
         x_ff         <= X0_Q[31:0];
         y_ff         <= Y0_Q[31:0];
         z_ff         <= Z0_Q[31:0];
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         stage_ff     <= stage_in;
         dt_ff        <= dt_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         z_ff         <= z_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      px_ff  <= px_in;  py_ff  <= py_in;  pz_ff  <= pz_in;
      kx_ff  <= kx_in;  ky_ff  <= ky_in;  kz_ff  <= kz_in;
      tmp_ff <= tmp_in;
      sx_ff  <= sx_in;  sy_ff  <= sy_in;  sz_ff  <= sz_in;
      plx_ff <= plx_in; ply_ff <= ply_in; plz_ff <= plz_in;
      rsp_sx_ff <= rsp_sx_in; rsp_sy_ff <= rsp_sy_in; rsp_sz_ff <= rsp_sz_in;
      rsp_px_ff <= rsp_px_in; rsp_py_ff <= rsp_py_in; rsp_pz_ff <= rsp_pz_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_state_x = rsp_sx_ff;
   assign rsp_state_y = rsp_sy_ff;
   assign rsp_state_z = rsp_sz_ff;
   assign rsp_plot_x  = rsp_px_ff;
   assign rsp_plot_y  = rsp_py_ff;
   assign rsp_plot_z  = rsp_pz_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("request taken while a beat is in work");

   a_load_state: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind) |=> (x_ff == $past(req_load_x) && z_ff == $past(req_load_z)))
      else $error("load beat did not set the state");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done state");

   a_div_op: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (op_ff == OP_FX || op_ff == OP_FY || op_ff == OP_FZ))
      else $error("divider wait with a non-final op");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Lorenz RK4 integrator unit.
// ----------------------------------------------------------------------------
// Step and load beats are sent under random idling on both sides. An in-bench
// fixed-point RK4 predictor tracks the state and dt, and every response beat is
// compared field by field with the oldest predicted beat. Covered: reset state,
// load extremes and saturation, dt extremes including zero, long response
// hold-off, and random trajectories with random loads.
// ----------------------------------------------------------------------------
module tb_top;

   typedef enum logic {OP_STEP = 1'b0, OP_LOAD = 1'b1} op_type;

   typedef struct packed {
      logic signed [31:0] sx, sy, sz, px, py, pz;
   } lorenz_beat_type;

   localparam longint ONE_Q    = 64'sd1 << 20;
   localparam longint K_SIGMA  = 10 * ONE_Q;
   localparam longint K_RHO    = 28 * ONE_Q;
   localparam longint K_BETA   = (16 * ONE_Q + 3) / 6;
   localparam longint K_25     = 25 * ONE_Q;
   localparam longint K_PLOT   = (6 * ONE_Q + 40) / 80;
   localparam logic [15:0] DT_RESET = 16'd4404;
   localparam int LIMIT_CYCLES = 3000000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_kind = OP_STEP;
   logic signed [31:0] req_load_x = '0, req_load_y = '0, req_load_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_state_x, rsp_state_y, rsp_state_z;
   logic signed [31:0] rsp_plot_x, rsp_plot_y, rsp_plot_z;
   logic               csr_wr_en = 1'b0;
   logic [15:0]        csr_wr_data = '0;

   lorenz_rk4_integrator_unit dut (
      .clock, .reset, .req_valid, .req_stall, .req_kind, .req_load_x, .req_load_y,
      .req_load_z, .rsp_valid, .rsp_stall, .rsp_state_x, .rsp_state_y, .rsp_state_z,
      .rsp_plot_x, .rsp_plot_y, .rsp_plot_z, .csr_wr_en, .csr_wr_data
   );

   // predictor state
   longint      pos_x = (18 * ONE_Q + 10) / 20;
   longint      pos_y = (34 * ONE_Q + 10) / 20;
   longint      pos_z = 21 * ONE_Q;
   logic [15:0] dt_q  = DT_RESET;

   lorenz_beat_type pending_beats[$];
   int  error_count = 0;
   int  cycle_count = 0;
   int  hold_cycles = 0;
   bit  no_idle = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint rnd_shift(longint p, int s);
      return (p + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return rnd_shift(a * b, 20);
   endfunction

   function automatic longint div_floor(longint p, longint d);
      longint q;
      q = p / d;
      if ((p % d) != 0 && p < 0) q = q - 1;
      return q;
   endfunction

   function automatic void lorenz_deriv(input longint x, y, z,
                                        output longint dx, dy, dz);
      dx = clamp32(K_SIGMA * (y - x) / ONE_Q);
      dy = clamp32(qmul(x, clamp32(K_RHO - z)) - y);
      dz = clamp32(qmul(x, y) - qmul(K_BETA, z));
   endfunction

   function automatic lorenz_beat_type advance_lorenz(op_type op, logic signed [31:0] lx,
                                                      logic signed [31:0] ly,
                                                      logic signed [31:0] lz);
      longint dt, x, y, z;
      longint k1x, k1y, k1z, k2x, k2y, k2z, k3x, k3y, k3z, k4x, k4y, k4z;
      lorenz_beat_type b;
      dt = longint'(dt_q);
      x = pos_x; y = pos_y; z = pos_z;
      if (op == OP_LOAD) begin
         pos_x = lx; pos_y = ly; pos_z = lz;
      end else begin
         lorenz_deriv(x, y, z, k1x, k1y, k1z);
         lorenz_deriv(clamp32(x + rnd_shift(dt * k1x, 21)), clamp32(y + rnd_shift(dt * k1y, 21)),
                      clamp32(z + rnd_shift(dt * k1z, 21)), k2x, k2y, k2z);
         lorenz_deriv(clamp32(x + rnd_shift(dt * k2x, 21)), clamp32(y + rnd_shift(dt * k2y, 21)),
                      clamp32(z + rnd_shift(dt * k2z, 21)), k3x, k3y, k3z);
         lorenz_deriv(clamp32(x + qmul(dt, k3x)), clamp32(y + qmul(dt, k3y)),
                      clamp32(z + qmul(dt, k3z)), k4x, k4y, k4z);
         pos_x = clamp32(x + div_floor(dt * (k1x + 2 * k2x + 2 * k3x + k4x) + 3 * ONE_Q,
                                       6 * ONE_Q));
         pos_y = clamp32(y + div_floor(dt * (k1y + 2 * k2y + 2 * k3y + k4y) + 3 * ONE_Q,
                                       6 * ONE_Q));
         pos_z = clamp32(z + div_floor(dt * (k1z + 2 * k2z + 2 * k3z + k4z) + 3 * ONE_Q,
                                       6 * ONE_Q));
      end
      b.sx = pos_x[31:0];
      b.sy = pos_y[31:0];
      b.sz = pos_z[31:0];
      b.px = 32'(clamp32(qmul(pos_x, K_PLOT)));
      b.py = 32'(clamp32(qmul(clamp32(pos_z - K_25), K_PLOT)));
      b.pz = 32'(clamp32(qmul(pos_y, K_PLOT)));
      return b;
   endfunction

   // request side: sends one beat, returns once accepted
   task automatic send_item(op_type op, logic signed [31:0] lx = 0,
                            logic signed [31:0] ly = 0, logic signed [31:0] lz = 0);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_kind   <= op;
      req_load_x <= ($urandom_range(0, 1) || op == OP_LOAD) ? lx : $urandom;
      req_load_y <= ly;
      req_load_z <= lz;
      do @(posedge clock); while (req_stall);
      pending_beats.push_back(advance_lorenz(op, lx, ly, lz));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_step_size(logic [15:0] v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      dt_q = v;
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_coord(int lo, int hi);
      return $signed($urandom_range(0, (hi - lo) << 20)) + (lo <<< 20);
   endfunction

   // response side: random stall per beat, plus a long hold-off on request
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         n = no_idle ? 0 : $urandom_range(0, 8);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid && hold_cycles == 0);
      end
   end

   always @(posedge clock) begin
      lorenz_beat_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_beats.size() == 0) begin
            $error("response beat with nothing expected");
            error_count++;
         end else begin
            e = pending_beats.pop_front();
            if (rsp_state_x !== e.sx) begin
               $error("state_x exp %0d got %0d", e.sx, rsp_state_x); error_count++;
            end
            if (rsp_state_y !== e.sy) begin
               $error("state_y exp %0d got %0d", e.sy, rsp_state_y); error_count++;
            end
            if (rsp_state_z !== e.sz) begin
               $error("state_z exp %0d got %0d", e.sz, rsp_state_z); error_count++;
            end
            if (rsp_plot_x !== e.px) begin
               $error("plot_x exp %0d got %0d", e.px, rsp_plot_x); error_count++;
            end
            if (rsp_plot_y !== e.py) begin
               $error("plot_y exp %0d got %0d", e.py, rsp_plot_y); error_count++;
            end
            if (rsp_plot_z !== e.pz) begin
               $error("plot_z exp %0d got %0d", e.pz, rsp_plot_z); error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic test_reset_trajectory();
      repeat (6) send_item(OP_STEP);
   endtask

   task automatic test_load_extremes();
      send_item(OP_LOAD, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
      send_item(OP_STEP);
      send_item(OP_LOAD, 32'sh80000000, 32'sh80000000, 32'sh80000000);
      send_item(OP_STEP);
      send_item(OP_LOAD, 32'sh7fffffff, 32'sh80000000, 32'sh00000000);
      send_item(OP_STEP);
      send_item(OP_STEP);
      send_item(OP_LOAD, 32'sh80000000, 32'sh7fffffff, 32'shffffffff);
      send_item(OP_STEP);
      send_item(OP_LOAD, 0, 0, 0);
      send_item(OP_STEP);
   endtask

   task automatic test_step_size_extremes();
      write_step_size(16'd65535);
      send_item(OP_LOAD, 32'sd943718, 32'sd1782579, 32'sd22020096);
      repeat (3) send_item(OP_STEP);
      write_step_size(16'd1);
      repeat (2) send_item(OP_STEP);
      write_step_size(16'd0);
      repeat (2) send_item(OP_STEP);
      write_step_size(DT_RESET);
   endtask

   task automatic test_backpressure();
      drain();
      hold_cycles = 3000;
      no_idle = 1'b1;
      repeat (8) send_item(OP_STEP);
      no_idle = 1'b0;
      drain();
   endtask

   task automatic test_random_trajectories();
      int seg;
      for (seg = 0; seg < 12; seg++) begin
         if (seg % 4 == 3) write_step_size(16'($urandom_range(1, 65535)));
         else if (seg % 4 == 1) write_step_size(16'($urandom_range(1000, 9000)));
         no_idle = (seg % 5 == 2);
         repeat (10) begin
            if ($urandom_range(0, 9) == 0)
               send_item(OP_LOAD, $urandom, $urandom, $urandom);
            else
               send_item(OP_LOAD, rand_coord(-25, 25), rand_coord(-30, 30),
                         rand_coord(0, 55));
            repeat ($urandom_range(3, 14)) send_item(OP_STEP);
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_trajectory();
      test_load_extremes();
      test_step_size_extremes();
      test_backpressure();
      test_random_trajectories();
      drain();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
